/* hdl/bppa_pkg.sv */
// Package: shared types, codes and helpers for the page pool allocator.
`timescale 1ns / 1ps
package bppa_pkg;

	localparam int WORD_BITS  = 32;
	localparam int WIDX_BITS  = 5;
	localparam int FRAME_BITS = 10;
	localparam int ADDR_BITS  = 32;
	localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;
	localparam logic [WIDX_BITS-1:0] LAST_WORD = 5'h1F;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NO_POOL  = 2'd2,
		ST_NOT_HELD = 2'd3
	} status_t;

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC,
		S_SWEEP,
		S_ARD,
		S_ACHK,
		S_FRD,
		S_FCHK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic sweep;
		logic alloc_rd;
		logic alloc_chk;
		logic free_rd;
		logic free_chk;
		logic full;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic kind;
		logic pool_end;
		logic need_setup;
		logic sweep_last;
		logic word_hit;
		logic word_last;
		logic free_hit;
		logic out_free;
	} stat_t;

	// index of the lowest clear bit
	function automatic logic [WIDX_BITS-1:0] first_zero(input logic [WORD_BITS-1:0] w);
		logic [WIDX_BITS-1:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) r = WIDX_BITS'(i);
		end
		return r;
	endfunction

endpackage

/* hdl/bppa_ctrl.sv */
// Controller: request sequencing state machine.
`timescale 1ns / 1ps
module bppa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  bppa_pkg::stat_t st,
	output bppa_pkg::cmd_t  cmd
);
	import bppa_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_d = (st.kind == KIND_FREE) ? S_FRD : S_ALLOC;
			S_ALLOC: begin
				if (st.pool_end)        state_d = S_DONE;
				else if (st.need_setup) state_d = S_SWEEP;
				else                    state_d = S_ARD;
			end
			S_SWEEP: if (st.sweep_last) state_d = S_ARD;
			S_ARD:   state_d = S_ACHK;
			S_ACHK: begin
				if (st.word_hit)       state_d = S_DONE;
				else if (st.word_last) state_d = S_ALLOC;
				else                   state_d = S_ARD;
			end
			S_FRD:   state_d = st.free_hit ? S_FCHK : S_DONE;
			S_FCHK:  state_d = S_DONE;
			S_DONE:  if (st.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_ALLOC: begin
				cmd.full  = st.pool_end;
				cmd.setup = !st.pool_end && st.need_setup;
			end
			S_SWEEP: cmd.sweep     = 1'b1;
			S_ARD:   cmd.alloc_rd  = 1'b1;
			S_ACHK:  cmd.alloc_chk = 1'b1;
			S_FRD:   cmd.free_rd   = 1'b1;
			S_FCHK:  cmd.free_chk  = 1'b1;
			S_DONE:  cmd.out_load  = st.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

/* hdl/bppa_dp.sv */
// Datapath: bitmap memory, pool tables, address math and result register.
`timescale 1ns / 1ps
module bppa_dp #(
	parameter int POOL_COUNT = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bppa_pkg::cmd_t                  cmd,
	output bppa_pkg::stat_t                 st,
	input  logic                            in_kind,
	input  logic [bppa_pkg::ADDR_BITS-1:0]  in_address,
	input  logic [bppa_pkg::FRAME_BITS-1:0] in_frame,
	input  logic [bppa_pkg::FRAME_BITS-1:0] virt_base,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      out_status,
	output logic [bppa_pkg::ADDR_BITS-1:0]  out_virt,
	output logic [bppa_pkg::ADDR_BITS-1:0]  out_phys,
	output logic                            out_took
);
	import bppa_pkg::*;

	localparam int PW    = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
	localparam int CW    = $clog2(POOL_COUNT + 1);
	localparam int AW    = PW + WIDX_BITS;
	localparam int DEPTH = POOL_COUNT * 32;

	logic [WORD_BITS-1:0]  mem [DEPTH];
	logic [WORD_BITS-1:0]  rdata_q;
	logic [WIDX_BITS-1:0]  lastw_q [POOL_COUNT];
	logic [FRAME_BITS-1:0] phys_q  [POOL_COUNT];

	logic [CW-1:0]         ready_cnt_q;
	logic [CW-1:0]         pool_q;
	logic [WIDX_BITS-1:0]  n_q;
	logic [WIDX_BITS-1:0]  w_q;
	logic [ADDR_BITS-1:0]  addr_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic                  took_q;

	status_t               res_status_q;
	logic [ADDR_BITS-1:0]  res_virt_q, res_phys_q;
	logic                  res_took_q;

	logic [PW-1:0]         pidx;
	logic [WIDX_BITS-1:0]  scan_w;
	logic [WIDX_BITS-1:0]  zbit;
	logic [FRAME_BITS-1:0] fdiff;
	logic                  fvalid;
	logic [WIDX_BITS-1:0]  fbit;
	logic [FRAME_BITS-1:0] vframe;

	logic                  we;
	logic [AW-1:0]         waddr, raddr;
	logic [WORD_BITS-1:0]  wdata;
	logic                  re;

	assign pidx   = pool_q[PW-1:0];
	assign scan_w = lastw_q[pidx] + n_q;
	assign zbit   = first_zero(rdata_q);
	// pool that maps the address is (frame - base) mod 1024, live if already set up
	assign fdiff  = addr_q[31:22] - virt_base;
	assign fvalid = fdiff < FRAME_BITS'(ready_cnt_q);
	assign fbit   = addr_q[16:12];
	assign vframe = virt_base + FRAME_BITS'(pool_q);

	assign st.kind       = in_kind;
	assign st.pool_end   = pool_q == CW'(POOL_COUNT);
	assign st.need_setup = pool_q >= ready_cnt_q;
	assign st.sweep_last = n_q == LAST_WORD;
	assign st.word_hit   = rdata_q != FULL_WORD;
	assign st.word_last  = n_q == LAST_WORD;
	assign st.free_hit   = fvalid;
	assign st.out_free   = !out_valid || out_ready;

	always_comb begin
		we    = 1'b0;
		waddr = {pidx, n_q};
		wdata = '0;
		re    = 1'b0;
		raddr = {pidx, scan_w};
		if (cmd.sweep) begin
			we = 1'b1;
		end
		if (cmd.alloc_chk && st.word_hit) begin
			we    = 1'b1;
			waddr = {pidx, w_q};
			wdata = rdata_q | (WORD_BITS'(1) << zbit);
		end
		if (cmd.alloc_rd) re = 1'b1;
		if (cmd.free_rd) begin
			re    = 1'b1;
			raddr = {fdiff[PW-1:0], addr_q[21:17]};
		end
		if (cmd.free_chk && rdata_q[fbit]) begin
			we    = 1'b1;
			waddr = {fdiff[PW-1:0], addr_q[21:17]};
			wdata = rdata_q & ~(WORD_BITS'(1) << fbit);
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q  <= in_address;
			frame_q <= in_frame;
			took_q  <= 1'b0;
		end
		if (cmd.setup) begin
			took_q        <= 1'b1;
			phys_q[pidx]  <= frame_q;
			lastw_q[pidx] <= '0;
		end
		if (cmd.alloc_rd) w_q <= scan_w;
		if (cmd.alloc_chk && st.word_hit) begin
			lastw_q[pidx] <= w_q;
			res_status_q  <= ST_OK;
			res_virt_q    <= {vframe, w_q, zbit, 12'h000};
			res_phys_q    <= {phys_q[pidx], w_q, zbit, 12'h000};
			res_took_q    <= took_q;
		end
		if (cmd.full) begin
			res_status_q <= ST_FULL;
			res_virt_q   <= '0;
			res_phys_q   <= '0;
			res_took_q   <= 1'b0;
		end
		if (cmd.free_rd && !fvalid) begin
			res_status_q <= ST_NO_POOL;
			res_virt_q   <= '0;
			res_phys_q   <= '0;
			res_took_q   <= 1'b0;
		end
		if (cmd.free_chk) begin
			res_status_q <= rdata_q[fbit] ? ST_OK : ST_NOT_HELD;
			res_virt_q   <= '0;
			res_phys_q   <= '0;
			res_took_q   <= 1'b0;
		end
		if (cmd.out_load) begin
			out_status <= res_status_q;
			out_virt   <= res_virt_q;
			out_phys   <= res_phys_q;
			out_took   <= res_took_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_cnt_q <= '0;
			pool_q      <= '0;
			n_q         <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (cmd.load) begin
				pool_q <= '0;
				n_q    <= '0;
			end
			if (cmd.setup) begin
				ready_cnt_q <= ready_cnt_q + CW'(1);
				n_q         <= '0;
			end
			if (cmd.sweep) n_q <= n_q + WIDX_BITS'(1);
			if (cmd.alloc_chk && !st.word_hit) begin
				n_q <= n_q + WIDX_BITS'(1);
				if (st.word_last) pool_q <= pool_q + CW'(1);
			end
			if (cmd.out_load)  out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

endmodule

/* hdl/bitmap_page_pool_allocator.sv */
// Top level: page pool allocator, stream request/response with config register.
//
// Requests enter on s_axis; tuser[0] is the kind (0 allocate, 1 free),
// tdata carries the address to free and the frame for a new pool.
// One response word per request leaves on m_axis: tuser holds status and
// the new-pool flag, tdata the virtual and physical page addresses.
// One request is worked at a time; s_axis_tready is high only while idle.
// Free reads the bitmap word, checks and updates it, then loads the output
// register; the check is skipped when the address is in no pool. Allocate
// reads and checks one bitmap word after another (memory read, then check)
// until a word has a clear bit; a full pool is passed over for the next,
// and a new pool is set up first, its bitmap words cleared one per cycle.
// The response sits in an output register; a new request is accepted
// while it waits, and that request's result waits in the block until
// the receiver takes the earlier word.
// Reset empties every pool and sets the virtual base to frame 772; the
// bitmap needs no clearing pass as each pool is cleared on set-up.
// cfg_we writes the virtual base frame; do so only while idle.
`timescale 1ns / 1ps
module bitmap_page_pool_allocator #(
	parameter int POOL_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // address[31:0], new_pool_frame[41:32], zero pad
	input  logic [0:0]  s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // virt_addr[31:0], phys_addr[63:32]
	output logic [2:0]  m_axis_tuser   // status[1:0], took_new_frame[2]
);
	import bppa_pkg::*;

	logic [FRAME_BITS-1:0] base_q;
	cmd_t  cmd;
	stat_t st;
	logic [1:0] status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     base_q <= 10'd772;
		else if (cfg_we) base_q <= cfg_wdata;
	end

	bppa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	bppa_dp #(.POOL_COUNT(POOL_COUNT)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.in_kind    (s_axis_tuser[0]),
		.in_address (s_axis_tdata[31:0]),
		.in_frame   (s_axis_tdata[41:32]),
		.virt_base  (base_q),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (status),
		.out_virt   (m_axis_tdata[31:0]),
		.out_phys   (m_axis_tdata[63:32]),
		.out_took   (m_axis_tuser[2])
	);

	assign m_axis_tuser[1:0] = status;

endmodule
